// File: hdl/sqv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqv_pkg
// Shared types and constants for the sprite quad vertex generator.
// ----------------------------------------------------------------------------
package sqv_pkg;

  localparam int PosW = 24;
  localparam int EdgeW = 32;
  localparam int CordW = 34;
  localparam int TableLen = 24;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032875;

  localparam logic [1:0] AnchorStart = 2'd1;
  localparam logic [1:0] AnchorEnd = 2'd2;
  localparam logic [1:0] ModeRound = 2'd0;
  localparam logic [1:0] ModeRotate = 2'd1;
  localparam logic [1:0] CornerLast = 2'd3;

  // Per-sprite data carried alongside the CORDIC pipe
  typedef struct packed {
    logic signed [PosW-1:0]  px;
    logic signed [PosW-1:0]  py;
    logic signed [PosW-1:0]  pz;
    logic signed [EdgeW-1:0] x0;
    logic signed [EdgeW-1:0] x1;
    logic signed [EdgeW-1:0] y0;
    logic signed [EdgeW-1:0] y1;
    logic [1:0]              mode;
  } span_t;

  // CORDIC rotation state
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
    logic                    flip;
  } cord_t;

  // Arctangent table, Q2.30 binary angle
  function automatic logic [31:0] atan_lut(input int idx);
    logic [31:0] r;
    begin
      case (idx)
        0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
        3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
        6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
        9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
        12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
        15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
        18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
        21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: hdl/sqv_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqv_cordic_stage
// One registered CORDIC rotation step; the sprite span rides along.
// ----------------------------------------------------------------------------
module sqv_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  sqv_pkg::cord_t in_c,
  input  sqv_pkg::span_t in_s,
  output logic           out_v_r,
  output sqv_pkg::cord_t out_c_r,
  output sqv_pkg::span_t out_s_r
);
  import sqv_pkg::*;

  localparam logic signed [CordW-1:0] Atan = CordW'(signed'({1'b0, atan_lut(IDX)}));

  cord_t c_nxt;

  // rotate toward zero residual angle
  always_comb begin
    c_nxt = in_c;
    if (!in_c.z[CordW-1]) begin
      c_nxt.x = in_c.x - (in_c.y >>> IDX);
      c_nxt.y = in_c.y + (in_c.x >>> IDX);
      c_nxt.z = in_c.z - Atan;
    end else begin
      c_nxt.x = in_c.x + (in_c.y >>> IDX);
      c_nxt.y = in_c.y - (in_c.x >>> IDX);
      c_nxt.z = in_c.z + Atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c_r <= c_nxt;
      out_s_r <= in_s;
    end
  end

endmodule

// File: hdl/sprite_quad_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator
// Turns one sprite request into its four corner vertices.
// ----------------------------------------------------------------------------
// A request passes through input, size, span, CORDIC_STEPS rotation stages
// (at most TableLen) and a product stage. The product stage then emits the
// four corners, one per cycle while the result side does not stall, in the
// order top-left, top-right, bottom-left, bottom-right; a new request is
// accepted every cycle the pipe moves, and the single result port sets the
// sustained rate, as the pipe holds until a sprite's fourth corner is taken.
// A stall on the result side freezes the whole pipe without losing anything.
module sprite_quad_vertex_generator #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic signed [15:0] in_scale_x,
  input  logic signed [15:0] in_scale_y,
  input  logic [15:0]        in_size_x,
  input  logic [15:0]        in_size_y,
  input  logic [1:0]         in_anchor_x,
  input  logic [1:0]         in_anchor_y,
  input  logic [1:0]         in_render_mode,
  input  logic [15:0]        in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_vert_x,
  output logic signed [23:0] out_vert_y,
  output logic signed [23:0] out_vert_z,
  output logic [1:0]         out_corner,
  output logic               out_last_corner
);
  import sqv_pkg::*;

  localparam int Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

  logic adv;

  // ---- stage 0: input register
  logic              v0_r;
  logic signed [23:0] px0_r, py0_r, pz0_r;
  logic signed [15:0] sx0_r, sy0_r;
  logic [15:0]        zx0_r, zy0_r, ang0_r;
  logic [1:0]         ax0_r, ay0_r, md0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px0_r <= in_pos_x;  py0_r <= in_pos_y;  pz0_r <= in_pos_z;
      sx0_r <= in_scale_x; sy0_r <= in_scale_y;
      zx0_r <= in_size_x;  zy0_r <= in_size_y;
      ax0_r <= in_anchor_x; ay0_r <= in_anchor_y;
      md0_r <= in_render_mode; ang0_r <= in_angle;
    end
  end

  // ---- stage 1: scale times size, angle folding
  logic               v1_r;
  logic signed [32:0] prx1_r, pry1_r;
  logic signed [23:0] px1_r, py1_r, pz1_r;
  logic [1:0]         ax1_r, ay1_r, md1_r;
  cord_t              c1_r;
  cord_t              c1_nxt;
  logic signed [31:0] a32;

  always_comb begin
    a32 = signed'({ang0_r, 16'h0000});
    c1_nxt.x = CordicGain;
    c1_nxt.y = '0;
    c1_nxt.flip = (a32 > 32'sh40000000) || (a32 < -32'sh40000000);
    if (c1_nxt.flip) c1_nxt.z = CordW'(signed'(a32 - 32'sh80000000));
    else c1_nxt.z = CordW'(a32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prx1_r <= sx0_r * signed'({1'b0, zx0_r});
      pry1_r <= sy0_r * signed'({1'b0, zy0_r});
      px1_r <= px0_r; py1_r <= py0_r; pz1_r <= pz0_r;
      ax1_r <= ax0_r; ay1_r <= ay0_r; md1_r <= md0_r;
      c1_r <= c1_nxt;
    end
  end

  // ---- stage 2: edges or offsets per axis
  function automatic logic [2*EdgeW-1:0] span(input logic signed [23:0] pos,
                                               input logic signed [32:0] prod,
                                               input logic [1:0] anc,
                                               input logic [1:0] md);
    logic signed [EdgeW-1:0] w, h, base, p, lo, f, s;
    begin
      w = EdgeW'(prod >>> 4);
      h = EdgeW'(prod >>> 5);
      p = EdgeW'(pos);
      base = (md == ModeRotate) ? '0 : p;
      if (anc == AnchorStart) begin
        f = base; s = base + w;
      end else if (anc == AnchorEnd) begin
        f = base - w; s = base;
      end else if (md == ModeRotate) begin
        f = -h; s = h;
      end else begin
        lo = p - h;
        if (md == ModeRound) lo = lo & ~EdgeW'(255);
        f = lo; s = lo + w;
      end
      return {f, s};
    end
  endfunction

  logic  v2_r;
  cord_t c2_r;
  span_t s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r <= c1_r;
      s2_r.px <= px1_r; s2_r.py <= py1_r; s2_r.pz <= pz1_r;
      s2_r.mode <= md1_r;
      {s2_r.x0, s2_r.x1} <= span(px1_r, prx1_r, ax1_r, md1_r);
      {s2_r.y0, s2_r.y1} <= span(py1_r, pry1_r, ay1_r, md1_r);
    end
  end

  // ---- CORDIC rotation stages
  logic  cv [0:Steps];
  cord_t cc [0:Steps];
  span_t cs [0:Steps];

  assign cv[0] = v2_r;
  assign cc[0] = c2_r;
  assign cs[0] = s2_r;

  for (genvar i = 0; i < Steps; i++) begin : g_cordic
    sqv_cordic_stage #(.IDX(i)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_v    (cv[i]),
      .in_c    (cc[i]),
      .in_s    (cs[i]),
      .out_v_r (cv[i+1]),
      .out_c_r (cc[i+1]),
      .out_s_r (cs[i+1])
    );
  end

  // ---- product stage and corner emitter
  logic signed [31:0] cos_q, sin_q;
  logic               vm_r;
  logic [1:0]         cnt_r;
  span_t              sm_r;
  logic signed [63:0] cx0_r, cx1_r, sx0p_r, sx1p_r, cy0_r, cy1_r, sy0p_r, sy1p_r;

  always_comb begin
    if (cc[Steps].flip) begin
      cos_q = 32'(-cc[Steps].x);
      sin_q = 32'(-cc[Steps].y);
    end else begin
      cos_q = 32'(cc[Steps].x);
      sin_q = 32'(cc[Steps].y);
    end
  end

  wire out_done = out_valid && !out_stall && (cnt_r == CornerLast);
  assign adv = !vm_r || out_done;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (adv) begin
        vm_r  <= cv[Steps];
        cnt_r <= '0;
      end else if (out_valid && !out_stall) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_r   <= cs[Steps];
      cx0_r  <= cos_q * cs[Steps].x0;
      cx1_r  <= cos_q * cs[Steps].x1;
      sx0p_r <= sin_q * cs[Steps].x0;
      sx1p_r <= sin_q * cs[Steps].x1;
      cy0_r  <= cos_q * cs[Steps].y0;
      cy1_r  <= cos_q * cs[Steps].y1;
      sy0p_r <= sin_q * cs[Steps].y0;
      sy1p_r <= sin_q * cs[Steps].y1;
    end
  end

  function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
    begin
      if (v > 36'sd8388607) return 24'sh7FFFFF;
      else if (v < -36'sd8388608) return 24'sh800000;
      else return v[23:0];
    end
  endfunction

  // per-corner sums
  logic signed [65:0] rx, ry;
  logic signed [35:0] vx, vy;
  logic signed [EdgeW-1:0] dx, dy;

  always_comb begin
    dx = cnt_r[0] ? sm_r.x1 : sm_r.x0;
    dy = cnt_r[1] ? sm_r.y1 : sm_r.y0;
    rx = 66'(cnt_r[0] ? cx1_r : cx0_r) - 66'(cnt_r[1] ? sy1p_r : sy0p_r)
         + 66'sd536870912;
    ry = 66'(cnt_r[1] ? cy1_r : cy0_r) + 66'(cnt_r[0] ? sx1p_r : sx0p_r)
         + 66'sd536870912;
    if (sm_r.mode == ModeRotate) begin
      vx = 36'(sm_r.px) + 36'(rx >>> 30);
      vy = 36'(sm_r.py) + 36'(ry >>> 30);
    end else begin
      vx = 36'(dx);
      vy = 36'(dy);
    end
  end

  assign out_valid       = vm_r;
  assign out_vert_x      = sat24(vx);
  assign out_vert_y      = sat24(vy);
  assign out_vert_z      = sm_r.pz;
  assign out_corner      = cnt_r;
  assign out_last_corner = (cnt_r == CornerLast);

endmodule

// File: hdl/sqv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqv_checker
// Port-level checks on the vertex stream of the quad generator.
// ----------------------------------------------------------------------------
module sqv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_vert_z,
  input logic [1:0]  out_corner,
  input logic        out_last_corner
);

  // last flag marks the fourth corner only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_corner == (out_corner == 2'd3)))
    else $error("last_corner mismatch");

  // a quad is never cut short
  a_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_corner) |=> out_valid)
    else $error("quad cut short");

  // corners advance in order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_corner) |=>
      (out_corner == $past(out_corner) + 2'd1))
    else $error("corner order broken");

  // depth is shared within a quad
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_corner) |=> $stable(out_vert_z))
    else $error("depth changed inside quad");

endmodule

bind sprite_quad_vertex_generator sqv_checker u_sqv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_vert_z      (out_vert_z),
  .out_corner      (out_corner),
  .out_last_corner (out_last_corner)
);

// File: tb/tb_sprite_quad_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_quad_vertex_generator
// Self-checking bench for the sprite quad vertex generator: a directed table
// of sprite requests, then random requests, each expanded into four corner
// vertices by a local predictor and compared in order at the output.
// ----------------------------------------------------------------------------
module tb_sprite_quad_vertex_generator;
  import sqv_pkg::*;

  localparam int Steps = 16;
  localparam int NumRandom = 450;
  localparam int CycleLimit = 400000;
  localparam logic [1:0] AnchorCenter = 2'd0;
  localparam logic [1:0] AnchorOdd = 2'd3;
  localparam logic [1:0] ModePlain = 2'd2;
  localparam logic [1:0] ModePlainAlt = 2'd3;
  localparam longint PosMax = 8388607;
  localparam longint PosMin = -8388608;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [15:0]        zx;
    logic [15:0]        zy;
    logic [1:0]         ax;
    logic [1:0]         ay;
    logic [1:0]         mode;
    logic [15:0]        ang;
  } sprite_t;

  localparam int SpriteW = $bits(sprite_t);

  typedef struct packed {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic [1:0]         corner;
    logic               last;
  } vertex_t;

  // Directed row: request plus optional typed-in corner coordinates
  typedef struct {
    sprite_t req;
    bit      typed;
    longint  tx[4];
    longint  ty[4];
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_scale_x = '0, in_scale_y = '0;
  logic [15:0] in_size_x = '0, in_size_y = '0, in_angle = '0;
  logic [1:0] in_anchor_x = '0, in_anchor_y = '0, in_render_mode = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_vert_x, out_vert_y, out_vert_z;
  logic [1:0] out_corner;
  logic out_last_corner;

  vertex_t pending_verts[$];
  int errors = 0;
  int vert_count = 0;
  int sprite_count = 0;
  int rotated_count = 0;
  int cycles = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 80;
  bit hold_off = 1'b0;
  row_t rows[$];

  sprite_quad_vertex_generator #(.CORDIC_STEPS(Steps)) dut (.*);

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL sprite_quad_vertex_generator");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > PosMax) return PosMax;
    if (v < PosMin) return PosMin;
    return v;
  endfunction

  // Sine and cosine in Q2.30 by fixed-length CORDIC
  function automatic void cordic_sincos(logic [15:0] ang, output longint c,
                                        output longint s);
    logic [31:0] a;
    longint x, y, z, dx, dy;
    bit flip;
    a = {ang, 16'h0};
    x = 652032875;
    y = 0;
    flip = 1'b0;
    z = longint'($signed(a));
    if (z > 64'sh40000000 || z < -64'sh40000000) begin
      z = longint'($signed(a - 32'h80000000));
      flip = 1'b1;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  // Edges or rotation offsets for one axis
  function automatic void axis_edges(longint pos, longint prod, logic [1:0] anc,
                                     logic [1:0] mode, output longint e0,
                                     output longint e1);
    longint w, h, base, lo;
    w = floor_shr(prod, 4);
    h = floor_shr(prod, 5);
    base = (mode == ModeRotate) ? 0 : pos;
    if (anc == AnchorStart) begin
      e0 = base; e1 = base + w;
    end else if (anc == AnchorEnd) begin
      e0 = base - w; e1 = base;
    end else if (mode == ModeRotate) begin
      e0 = -h; e1 = h;
    end else begin
      lo = pos - h;
      if (mode == ModeRound) lo = floor_shr(lo, 8) * 256;
      e0 = lo; e1 = lo + w;
    end
  endfunction

  // Predict the four corners of a sprite and queue them
  function automatic void predict_quad(sprite_t r);
    longint xs[2], ys[2], c, s, dx, dy, vx, vy;
    vertex_t v;
    axis_edges(r.px, longint'(r.sx) * longint'({1'b0, r.zx}), r.ax, r.mode,
               xs[0], xs[1]);
    axis_edges(r.py, longint'(r.sy) * longint'({1'b0, r.zy}), r.ay, r.mode,
               ys[0], ys[1]);
    c = 0;
    s = 0;
    if (r.mode == ModeRotate) cordic_sincos(r.ang, c, s);
    for (int k = 0; k < 4; k++) begin
      dx = xs[k & 1];
      dy = ys[k >> 1];
      if (r.mode == ModeRotate) begin
        vx = r.px + floor_shr(c * dx - s * dy + (64'sd1 <<< 29), 30);
        vy = r.py + floor_shr(c * dy + s * dx + (64'sd1 <<< 29), 30);
      end else begin
        vx = dx;
        vy = dy;
      end
      v.vx = 24'(clamp24(vx));
      v.vy = 24'(clamp24(vy));
      v.vz = r.pz;
      v.corner = 2'(k);
      v.last = (k == 3);
      pending_verts.push_back(v);
    end
  endfunction

  function automatic sprite_t mk(longint px, longint py, longint pz, longint sx,
                                 longint sy, longint zx, longint zy,
                                 logic [1:0] ax, logic [1:0] ay,
                                 logic [1:0] mode, longint ang);
    sprite_t r;
    r.px = 24'(px); r.py = 24'(py); r.pz = 24'(pz);
    r.sx = 16'(sx); r.sy = 16'(sy); r.zx = 16'(zx); r.zy = 16'(zy);
    r.ax = ax; r.ay = ay; r.mode = mode; r.ang = 16'(ang);
    return r;
  endfunction

  function automatic void add_row(sprite_t r);
    row_t w;
    w.req = r;
    w.typed = 1'b0;
    rows.push_back(w);
  endfunction

  function automatic void add_typed(sprite_t r, longint x0, longint x1,
                                    longint y0, longint y1);
    row_t w;
    w.req = r;
    w.typed = 1'b1;
    for (int k = 0; k < 4; k++) begin
      w.tx[k] = (k & 1) ? x1 : x0;
      w.ty[k] = (k >> 1) ? y1 : y0;
    end
    rows.push_back(w);
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t r;
    int pick;
    r = SpriteW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    pick = $urandom_range(0, 9);
    // mostly modest sizes and positions so corners stay in range
    if (pick < 7) begin
      r.px = 24'($signed(20'($urandom)));
      r.py = 24'($signed(20'($urandom)));
      r.sx = 16'($signed(11'($urandom)));
      r.sy = 16'($signed(11'($urandom)));
      r.zx = 16'($urandom_range(0, 4095));
      r.zy = 16'($urandom_range(0, 4095));
    end
    if ($urandom_range(0, 2) != 0) r.mode = ModeRotate;
    return r;
  endfunction

  // Offer one sprite, holding it until accepted; valid stays up afterwards
  // so a following transaction can go out back to back
  task automatic send_sprite(sprite_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_pos_x, in_pos_y, in_pos_z, in_scale_x, in_scale_y, in_size_x, in_size_y,
     in_anchor_x, in_anchor_y, in_render_mode, in_angle} <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sprite_count++;
    if (r.mode == ModeRotate) rotated_count++;
    @(negedge clk);
  endtask

  // Receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Compare each vertex with the oldest expectation
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_valid && !out_stall) begin
      vert_count++;
      if (pending_verts.size() == 0) begin
        $error("vertex with nothing expected: x=%0d y=%0d", out_vert_x, out_vert_y);
        errors++;
      end else begin
        e = pending_verts.pop_front();
        if (out_vert_x !== e.vx) begin
          $error("vert_x expected %0d got %0d", e.vx, out_vert_x); errors++;
        end
        if (out_vert_y !== e.vy) begin
          $error("vert_y expected %0d got %0d", e.vy, out_vert_y); errors++;
        end
        if (out_vert_z !== e.vz) begin
          $error("vert_z expected %0d got %0d", e.vz, out_vert_z); errors++;
        end
        if (out_corner !== e.corner) begin
          $error("corner expected %0d got %0d", e.corner, out_corner); errors++;
        end
        if (out_last_corner !== e.last) begin
          $error("last_corner expected %0d got %0d", e.last, out_last_corner);
          errors++;
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    sprite_t r;

    // Directed table; typed rows have answers readable at a glance
    add_typed(mk(0, 0, 0, 0, 0, 0, 0, AnchorCenter, AnchorCenter, ModeRound, 0),
              0, 0, 0, 0);
    add_typed(mk(1000, 2000, 77, 256, 256, 16, 32, AnchorStart, AnchorStart,
                 ModePlain, 0), 1000, 1256, 2000, 2512);
    add_typed(mk(1000, 2000, -5, 256, 256, 16, 32, AnchorEnd, AnchorEnd,
                 ModePlainAlt, 0), 744, 1000, 1488, 2000);
    add_typed(mk(PosMax, PosMin, PosMax, 32767, 32767, 65535, 65535,
                 AnchorStart, AnchorEnd, ModePlain, 0), PosMax, PosMax, PosMin,
              PosMin);
    add_typed(mk(PosMin, PosMax, PosMin, -32768, -32768, 65535, 65535,
                 AnchorStart, AnchorStart, ModePlain, 65535), PosMin, PosMin,
              PosMax, PosMin);
    add_row(mk(300, -300, 9, 256, 256, 16, 16, AnchorCenter, AnchorCenter,
               ModeRound, 0));
    add_row(mk(300, -300, 9, 256, 256, 16, 16, AnchorCenter, AnchorCenter,
               ModePlain, 0));
    add_row(mk(-77, 129, 1, 100, 300, 50, 7, AnchorOdd, AnchorOdd, ModeRound, 0));
    add_row(mk(5000, 5000, 3, -256, -512, 64, 32, AnchorCenter, AnchorStart,
               ModeRound, 0));
    add_row(mk(5000, 5000, 3, -256, 256, 64, 32, AnchorEnd, AnchorCenter,
               ModePlain, 0));
    for (int a = 0; a < 8; a++)
      add_row(mk(1234, -4321, a, 384, 200, 160, 96, 2'(a % 4), 2'((a + 1) % 4),
                 ModeRotate, a * 8192 + (a == 7 ? 8191 : 0)));
    add_row(mk(0, 0, 0, 256, 256, 16, 16, AnchorCenter, AnchorCenter, ModeRotate,
               16384));
    add_row(mk(0, 0, 0, 256, 256, 16, 16, AnchorCenter, AnchorCenter, ModeRotate,
               16385));
    add_row(mk(0, 0, 0, 256, 256, 16, 16, AnchorCenter, AnchorCenter, ModeRotate,
               49152));
    add_row(mk(PosMax, PosMax, 0, 32767, 32767, 65535, 65535, AnchorOdd,
               AnchorOdd, ModeRotate, 12345));
    add_row(mk(PosMin, PosMin, 0, -32768, 32767, 65535, 0, AnchorEnd, AnchorStart,
               ModeRotate, 65535));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      predict_quad(rows[i].req);
      if (rows[i].typed)
        for (int k = 0; k < 4; k++) begin
          vertex_t e;
          e = pending_verts[pending_verts.size() - 4 + k];
          if (e.vx != 24'(rows[i].tx[k]) || e.vy != 24'(rows[i].ty[k])) begin
            $error("table row %0d corner %0d: x expected %0d got %0d, y expected %0d got %0d",
                   i, k, rows[i].tx[k], e.vx, rows[i].ty[k], e.vy);
            errors++;
          end
        end
      send_sprite(rows[i].req);
    end

    // Random part in three idling phases, long receiver hold-off in the first
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin
        send_idle_pct = 80; recv_idle_pct = 9;
      end else if (n == 2 * NumRandom / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (n == 20) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      r = random_sprite();
      predict_quad(r);
      send_sprite(r);
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending_verts.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (Steps + 10) @(posedge clk);
    $display("Sent %0d sprites (%0d rotated), checked %0d vertices.",
             sprite_count, rotated_count, vert_count);
    if (errors == 0 && pending_verts.size() == 0) begin
      $display("PASS sprite_quad_vertex_generator");
    end else begin
      $display("FAIL sprite_quad_vertex_generator");
    end
    $finish;
  end

endmodule
